// File: src/fpba_pkg.sv
// ----------------------------------------------------------------------------
// fpba_pkg
// Shared codes, widths and types of the fit-policy block allocator.
// ----------------------------------------------------------------------------
package fpba_pkg;

  localparam int IN_IDX_W  = 4;
  localparam int IO_SIZE_W = 16;
  localparam int POLICY_W  = 2;
  localparam int BIU_W     = 5;
  localparam int CFG_W     = 5;
  localparam int CFG_IDX_W = 1;

  localparam logic                 MODE_LOAD = 1'b0;
  localparam logic                 MODE_REQ  = 1'b1;

  localparam logic [POLICY_W-1:0]  FIT_FIRST = 2'd0;
  localparam logic [POLICY_W-1:0]  FIT_BEST  = 2'd1;
  localparam logic [POLICY_W-1:0]  FIT_WORST = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_FIT_POLICY    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCKS_IN_USE = 1'b1;

  localparam logic [BIU_W-1:0]     BIU_RESET = 5'd16;

  typedef struct packed {
    logic clear;
    logic sample;
  } scan_ctl_t;

endpackage

// File: src/fpba_ram.sv
// ----------------------------------------------------------------------------
// fpba_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module fpba_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic                                 re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/fpba_scan.sv
// ----------------------------------------------------------------------------
// fpba_scan
// Candidate selector: compares one block entry per cycle against the request
// and keeps the pick under the active fit policy.
// ----------------------------------------------------------------------------
module fpba_scan
  import fpba_pkg::*;
#(
  parameter int NUM_BLOCKS = 16,
  parameter int SIZE_BITS  = 16
) (
  input  logic                                           clk,
  input  logic                                           rst_n,
  input  scan_ctl_t                                      ctl,
  input  logic [POLICY_W-1:0]                            policy,
  input  logic [IO_SIZE_W-1:0]                           req_size,
  input  logic [SIZE_BITS-1:0]                           rd_data,
  input  logic [(NUM_BLOCKS > 1 ? $clog2(NUM_BLOCKS) : 1)-1:0] rd_idx,
  output logic                                           found,
  output logic [(NUM_BLOCKS > 1 ? $clog2(NUM_BLOCKS) : 1)-1:0] pick,
  output logic [SIZE_BITS-1:0]                           best
);

  localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int CMP_W = (SIZE_BITS > IO_SIZE_W) ? SIZE_BITS : IO_SIZE_W;

  logic             found_r;
  logic [IDX_W-1:0] pick_r;
  logic [SIZE_BITS-1:0] best_r;
  logic             adequate;
  logic             take;

  always_comb begin
    adequate = CMP_W'(rd_data) >= CMP_W'(req_size);
    take     = 1'b0;
    if (ctl.sample && adequate) begin
      priority if (!found_r) begin
        take = 1'b1;
      end else if (policy == FIT_BEST) begin
        take = rd_data < best_r;
      end else if (policy == FIT_WORST) begin
        take = rd_data > best_r;
      end else begin
        take = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else if (ctl.clear) begin
      found_r <= 1'b0;
    end else if (take) begin
      found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      pick_r <= rd_idx;
      best_r <= rd_data;
    end
  end

  assign found = found_r;
  assign pick  = pick_r;
  assign best  = best_r;

endmodule

// File: src/fit_policy_block_allocator_top.sv
// ----------------------------------------------------------------------------
// fit_policy_block_allocator_top
// Free-size table of memory blocks with first, best and worst fit placement.
// ----------------------------------------------------------------------------
// The block table sits in one RAM with a single read port and a registered
// read, so a request reads one entry per cycle. A request scans the first
// min(blocks_in_use, NUM_BLOCKS) entries, writes the reduced free size back
// to the picked entry if one fits, and hands its result to the output
// register once that register is free. A load, or a request with zero
// blocks in use, skips the scan. One word is in work at a time; a finished
// result waits in the output register while the next word is taken.
// The table needs no clearing after reset: every block must be loaded before
// a request scans it.
// ----------------------------------------------------------------------------
module fit_policy_block_allocator_top
  import fpba_pkg::*;
#(
  parameter int NUM_BLOCKS = 16,
  parameter int SIZE_BITS  = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_mode,
  input  logic [IN_IDX_W-1:0]  in_block_index,
  input  logic [IO_SIZE_W-1:0] in_size_value,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_placed,
  output logic [IN_IDX_W-1:0]  out_chosen_block,
  output logic [IO_SIZE_W-1:0] out_space_left
);

  localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int CNT_W = $clog2(NUM_BLOCKS + 1);
  localparam int LIM_W = (CNT_W > BIU_W) ? CNT_W : BIU_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPD,
    ST_DONE
  } state_t;

  state_t               state_r;
  logic [POLICY_W-1:0]  policy_r;
  logic [BIU_W-1:0]     biu_r;
  logic [IO_SIZE_W-1:0] size_r;
  logic [CNT_W-1:0]     limit_r;
  logic [CNT_W-1:0]     cnt_r;
  logic                 samp_vld_r;
  logic [IDX_W-1:0]     samp_idx_r;
  logic                 res_placed_r;
  logic [IN_IDX_W-1:0]  res_block_r;
  logic [IO_SIZE_W-1:0] res_space_r;
  logic                 out_valid_r;
  logic                 out_placed_r;
  logic [IN_IDX_W-1:0]  out_block_r;
  logic [IO_SIZE_W-1:0] out_space_r;

  logic                 in_acc;
  logic                 idx_ok;
  logic [LIM_W-1:0]     biu_ext;
  logic [CNT_W-1:0]     limit;
  logic                 issue_first;
  logic                 issue_more;
  logic                 ram_re;
  logic [IDX_W-1:0]     ram_raddr;
  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic [SIZE_BITS-1:0] ram_wdata;
  logic [SIZE_BITS-1:0] ram_rdata;
  logic                 load_wr;
  logic                 upd_wr;
  logic                 out_free;
  logic [SIZE_BITS-1:0] stored;
  logic [SIZE_BITS-1:0] new_rem;
  scan_ctl_t            scan_ctl;
  logic                 found;
  logic [IDX_W-1:0]     pick;
  logic [SIZE_BITS-1:0] best;

  always_comb begin
    in_ready    = state_r == ST_IDLE;
    in_acc      = in_valid && in_ready;
    idx_ok      = 32'(in_block_index) < NUM_BLOCKS;
    biu_ext     = LIM_W'(biu_r);
    limit       = (biu_ext > LIM_W'(NUM_BLOCKS)) ? CNT_W'(NUM_BLOCKS) : CNT_W'(biu_ext);
    stored      = SIZE_BITS'(in_size_value);
    new_rem     = best - SIZE_BITS'(size_r);
    issue_first = in_acc && (in_mode == MODE_REQ) && (limit != '0);
    issue_more  = (state_r == ST_SCAN) && (cnt_r < limit_r);
    ram_re      = issue_first || issue_more;
    ram_raddr   = issue_first ? '0 : cnt_r[IDX_W-1:0];
    load_wr     = in_acc && (in_mode == MODE_LOAD) && idx_ok;
    upd_wr      = (state_r == ST_UPD) && found;
    ram_we      = load_wr || upd_wr;
    ram_waddr   = upd_wr ? pick : IDX_W'(in_block_index);
    ram_wdata   = upd_wr ? new_rem : stored;
    out_free    = !out_valid_r || out_ready;
    scan_ctl.clear  = in_acc;
    scan_ctl.sample = samp_vld_r;
  end

  fpba_ram #(
    .WIDTH (SIZE_BITS),
    .DEPTH (NUM_BLOCKS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  fpba_scan #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .SIZE_BITS  (SIZE_BITS)
  ) u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (scan_ctl),
    .policy   (policy_r),
    .req_size (size_r),
    .rd_data  (ram_rdata),
    .rd_idx   (samp_idx_r),
    .found    (found),
    .pick     (pick),
    .best     (best)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      policy_r    <= FIT_FIRST;
      biu_r       <= BIU_RESET;
      samp_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_FIT_POLICY:    policy_r <= cfg_wdata[POLICY_W-1:0];
          REG_BLOCKS_IN_USE: biu_r    <= cfg_wdata[BIU_W-1:0];
          default:           ;
        endcase
      end
      samp_vld_r <= ram_re;
      samp_idx_r <= ram_raddr;
      if (out_valid_r && out_ready && state_r != ST_DONE) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            size_r  <= in_size_value;
            limit_r <= limit;
            if (in_mode == MODE_LOAD) begin
              res_placed_r <= 1'b0;
              res_block_r  <= in_block_index;
              res_space_r  <= IO_SIZE_W'(stored);
              state_r      <= ST_DONE;
            end else if (limit == '0) begin
              res_placed_r <= 1'b0;
              res_block_r  <= '0;
              res_space_r  <= '0;
              state_r      <= ST_DONE;
            end else begin
              cnt_r   <= CNT_W'(1);
              state_r <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (issue_more) begin
            cnt_r <= cnt_r + CNT_W'(1);
          end else begin
            state_r <= ST_UPD;
          end
        end
        ST_UPD: begin
          res_placed_r <= found;
          res_block_r  <= found ? IN_IDX_W'(pick) : '0;
          res_space_r  <= found ? IO_SIZE_W'(new_rem) : '0;
          state_r      <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_placed_r <= res_placed_r;
            out_block_r  <= res_block_r;
            out_space_r  <= res_space_r;
            state_r      <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_placed       = out_placed_r;
  assign out_chosen_block = out_block_r;
  assign out_space_left   = out_space_r;

  a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> !ram_we)
    else $error("table written during scan");

  a_cnt_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (cnt_r <= limit_r))
    else $error("scan count beyond limit");

  a_pick_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPD && found) |-> (CNT_W'(pick) < limit_r))
    else $error("pick outside scanned range");

  a_done_delivers: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && out_free) |=> (out_valid_r && state_r == ST_IDLE))
    else $error("result not delivered");

endmodule

// File: tb/fit_policy_block_allocator_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fit_policy_block_allocator_top_test
// Self-checking bench for the first, best and worst fit block allocator.
// ----------------------------------------------------------------------------
// Loads every block, then sends load and request words through the valid and
// ready channels with random gaps and output stalls. Every accepted word is
// run through a local allocation table that predicts placed, chosen_block and
// space_left. The results are compared in order. Configuration changes happen
// only while the block is idle, and cover every fit code and blocks_in_use
// from zero up to beyond the table size.
// ----------------------------------------------------------------------------
module fit_policy_block_allocator_top_test;
  import fpba_pkg::*;

  localparam int NUM_BLOCKS   = 16;
  localparam int DRAIN_CYCLES = 24;
  localparam int HOLD_CYCLES  = 80;

  localparam logic [POLICY_W-1:0] FIT_UNUSED = 2'd3;

  typedef struct packed {
    logic                 placed;
    logic [IN_IDX_W-1:0]  chosen_block;
    logic [IO_SIZE_W-1:0] space_left;
  } alloc_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_FIT_POLICY;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 in_mode = MODE_LOAD;
  logic [IN_IDX_W-1:0]  in_block_index = '0;
  logic [IO_SIZE_W-1:0] in_size_value = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 out_placed;
  logic [IN_IDX_W-1:0]  out_chosen_block;
  logic [IO_SIZE_W-1:0] out_space_left;

  logic [IO_SIZE_W-1:0] free_size [NUM_BLOCKS];
  logic [POLICY_W-1:0]  fit_cfg = FIT_FIRST;
  logic [BIU_W-1:0]     blocks_cfg = BIU_RESET;

  alloc_result_t expected_q [$];
  int  fail_count = 0;
  int  words_sent = 0;
  int  results_seen = 0;
  int  placed_seen = 0;
  bit  gaps_on = 1'b1;
  bit  hold_req = 1'b0;

  fit_policy_block_allocator_top uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_mode          (in_mode),
    .in_block_index   (in_block_index),
    .in_size_value    (in_size_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_placed       (out_placed),
    .out_chosen_block (out_chosen_block),
    .out_space_left   (out_space_left)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic alloc_result_t place_word(logic mode, logic [IN_IDX_W-1:0] idx,
                                               logic [IO_SIZE_W-1:0] size);
    alloc_result_t r;
    int            scan_n;
    int            j;
    int            pick;
    bit            found;
    r = '0;
    if (mode == MODE_LOAD) begin
      free_size[idx] = size;
      r.chosen_block = idx;
      r.space_left   = size;
      return r;
    end
    scan_n = (blocks_cfg > NUM_BLOCKS) ? NUM_BLOCKS : int'(blocks_cfg);
    found  = 1'b0;
    pick   = 0;
    for (j = 0; j < scan_n; j++) begin
      if (free_size[j] >= size) begin
        if (!found) begin
          found = 1'b1;
          pick  = j;
          if (fit_cfg != FIT_BEST && fit_cfg != FIT_WORST) break;
        end else if (fit_cfg == FIT_BEST) begin
          if (free_size[j] < free_size[pick]) pick = j;
        end else if (fit_cfg == FIT_WORST) begin
          if (free_size[j] > free_size[pick]) pick = j;
        end
      end
    end
    if (found) begin
      free_size[pick] = free_size[pick] - size;
      r.placed        = 1'b1;
      r.chosen_block  = pick[IN_IDX_W-1:0];
      r.space_left    = free_size[pick];
    end
    return r;
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    if (idx == REG_FIT_POLICY) fit_cfg = data[POLICY_W-1:0];
    else blocks_cfg = data;
  endtask

  // upper bits of the fit code are don't-care and get random values
  task automatic set_config(logic [POLICY_W-1:0] fit, logic [CFG_W-1:0] blocks);
    write_reg(REG_FIT_POLICY, {3'($urandom), fit});
    write_reg(REG_BLOCKS_IN_USE, blocks);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_word(logic mode, logic [IN_IDX_W-1:0] idx, logic [IO_SIZE_W-1:0] size);
    int gap;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 3);
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_mode        <= mode;
    in_block_index <= idx;
    in_size_value  <= size;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_q.push_back(place_word(mode, idx, size));
    words_sent++;
  endtask

  task automatic send_random_word();
    logic [IN_IDX_W-1:0]  idx;
    logic [IO_SIZE_W-1:0] size;
    idx = IN_IDX_W'($urandom);
    if ($urandom_range(0, 9) < 3) begin
      size = $urandom_range(0, 1) ? IO_SIZE_W'($urandom) : IO_SIZE_W'($urandom_range(0, 4095));
      send_word(MODE_LOAD, idx, size);
    end else begin
      case ($urandom_range(0, 5))
        0: size = IO_SIZE_W'($urandom);
        1: size = IO_SIZE_W'($urandom_range(0, 64));
        2: size = free_size[idx];
        3: size = free_size[idx] >> 1;
        default: size = IO_SIZE_W'($urandom_range(0, free_size[idx]));
      endcase
      send_word(MODE_REQ, idx, size);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // every block gets loaded here before any request scans the table
  task automatic test_directed_cases();
    int i;
    send_word(MODE_LOAD, 4'd0, 16'd100);
    send_word(MODE_LOAD, 4'd1, 16'd0);
    send_word(MODE_LOAD, 4'd2, 16'hFFFF);
    send_word(MODE_LOAD, 4'd3, 16'd300);
    send_word(MODE_LOAD, 4'd4, 16'd100);
    send_word(MODE_LOAD, 4'd5, 16'd40000);
    for (i = 6; i < NUM_BLOCKS; i++) send_word(MODE_LOAD, i[IN_IDX_W-1:0], 16'(1000 * i));
    send_word(MODE_REQ, 4'd0, 16'd150);
    send_word(MODE_REQ, 4'hF, 16'd0);
    drain();
    set_config(FIT_BEST, 5'd16);
    send_word(MODE_REQ, 4'd7, 16'd100);
    drain();
    set_config(FIT_WORST, 5'd16);
    send_word(MODE_REQ, 4'd0, 16'hFFFF);
    send_word(MODE_REQ, 4'd0, 16'hFFFF);
    drain();
    set_config(FIT_UNUSED, 5'd31);
    send_word(MODE_REQ, 4'd3, 16'd10);
    drain();
    set_config(FIT_FIRST, 5'd0);
    send_word(MODE_REQ, 4'd0, 16'd0);
    drain();
    set_config(FIT_BEST, 5'd1);
    send_word(MODE_REQ, 4'd0, 16'd1);
    drain();
  endtask

  task automatic test_random_mix();
    logic [CFG_W-1:0] blocks;
    int               phase;
    int               n;
    for (phase = 0; phase < 8; phase++) begin
      case (phase)
        0, 3:    blocks = 5'd16;
        1:       blocks = 5'd1;
        2:       blocks = 5'd31;
        4:       blocks = 5'($urandom_range(2, 15));
        default: blocks = 5'($urandom_range(1, 31));
      endcase
      set_config(POLICY_W'(phase % 4), blocks);
      for (n = 0; n < 65; n++) send_random_word();
      drain();
    end
  endtask

  task automatic test_output_backpressure();
    int n;
    set_config(FIT_BEST, 5'd16);
    hold_req = 1'b1;
    for (n = 0; n < 40; n++) send_random_word();
    drain();
  endtask

  task automatic test_steady_stream();
    int n;
    gaps_on = 1'b0;
    set_config(FIT_WORST, 5'd16);
    for (n = 0; n < 60; n++) send_random_word();
    drain();
    set_config(FIT_FIRST, 5'd16);
    for (n = 0; n < 30; n++) send_random_word();
    drain();
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (gaps_on && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(0, 2)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    alloc_result_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        $error("result with nothing expected: placed %0d chosen_block %0d space_left %0d",
               out_placed, out_chosen_block, out_space_left);
        fail_count++;
      end else begin
        want = expected_q.pop_front();
        if (want.placed) placed_seen++;
        if (out_placed !== want.placed) begin
          $error("placed: expected %0d, got %0d", want.placed, out_placed);
          fail_count++;
        end
        if (out_chosen_block !== want.chosen_block) begin
          $error("chosen_block: expected %0d, got %0d", want.chosen_block, out_chosen_block);
          fail_count++;
        end
        if (out_space_left !== want.space_left) begin
          $error("space_left: expected %0d, got %0d", want.space_left, out_space_left);
          fail_count++;
        end
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_random_mix();
    test_output_backpressure();
    test_steady_stream();
    $display("%0d words sent, %0d results checked, %0d of them placed", words_sent,
             results_seen, placed_seen);
    $display("fit codes 0 to 3, blocks_in_use 0 to 31, gaps, long output hold, steady stream");
    if (fail_count == 0) begin
      $display("fit_policy_block_allocator_top_test: clean");
    end else begin
      $display("fit_policy_block_allocator_top_test: errors");
    end
    $finish;
  end

  initial begin
    #3ms;
    $display("timeout after %0d words, %0d results pending", words_sent, expected_q.size());
    $display("fit_policy_block_allocator_top_test: errors");
    $finish;
  end

endmodule
